FILE: sv/http_response_head_parser_defines.svh
// assertion macros for the http response head parser
// used by the top level only; expects clk and rst_n in scope
`ifndef HTTP_RESPONSE_HEAD_PARSER_DEFINES_SVH
`define HTTP_RESPONSE_HEAD_PARSER_DEFINES_SVH

// same-cycle implication
`define HRHP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrhp assertion failed");

// next-cycle implication
`define HRHP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrhp assertion failed");

`endif

FILE: sv/hrhp_pkg.sv
// types, codes and byte-class helpers for the http response head parser
// no dependencies
`default_nettype none

package hrhp_pkg;

    typedef enum logic [4:0] {
        PH_H,
        PH_T1,
        PH_T2,
        PH_P,
        PH_SLASH,
        PH_MAJ_START,
        PH_MAJ,
        PH_MIN_START,
        PH_MIN,
        PH_CODE_START,
        PH_CODE,
        PH_MSG_START,
        PH_MSG,
        PH_NL1,
        PH_HDR_START,
        PH_HDR,
        PH_NL2,
        PH_NL3,
        PH_BODY,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic vdone;
        logic neg;
        logic started;
        logic capture;
        logic found;
        logic colon;
    } flags_t;

    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [2:0] KIND_FRAMING = 3'd0;
    localparam logic [2:0] KIND_REASON  = 3'd1;
    localparam logic [2:0] KIND_HEADER  = 3'd2;
    localparam logic [2:0] KIND_LINE_OK = 3'd3;
    localparam logic [2:0] KIND_BODY    = 3'd4;

    localparam logic [4:0] POS_NONE  = 5'd0;
    localparam logic [4:0] POS_FULL  = 5'd14;
    localparam logic [4:0] POS_TRAIL = 5'd15;
    localparam logic [4:0] POS_MISS  = 5'd31;

    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) ? (c + 8'd32) : c;
    endfunction

    // lower-case "content-length", one letter per position
    function automatic logic [7:0] cl_char(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'h63;
            4'd1:    r = 8'h6f;
            4'd2:    r = 8'h6e;
            4'd3:    r = 8'h74;
            4'd4:    r = 8'h65;
            4'd5:    r = 8'h6e;
            4'd6:    r = 8'h74;
            4'd7:    r = 8'h2d;
            4'd8:    r = 8'h6c;
            4'd9:    r = 8'h65;
            4'd10:   r = 8'h6e;
            4'd11:   r = 8'h67;
            4'd12:   r = 8'h74;
            4'd13:   r = 8'h68;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // acc*10 + d, clamped to all ones
    function automatic logic [7:0] sat_dec8(input logic [7:0] acc, input logic [3:0] d);
        logic [11:0] w;
        w = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {8'b0, d};
        return (|w[11:8]) ? 8'hff : w[7:0];
    endfunction

    function automatic logic [15:0] sat_dec16(input logic [15:0] acc, input logic [3:0] d);
        logic [19:0] w;
        w = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, d};
        return (|w[19:16]) ? 16'hffff : w[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/http_response_head_parser.sv
// http response head parser: byte-wise status line, header and body tracking
// depends on hrhp_pkg and http_response_head_parser_defines.svh
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid in_ready rx_byte restart | into block
//  out     | out_valid out_ready parse_status  | out of block
//          | byte_kind data_byte version_major |
//          | version_minor status_code         |
//          | body_length                       |
//
// one beat per cycle sustained unless out_ready stalls the result register
// input register feeds one level of decode logic that updates parser state and
// loads the result register in the same edge
// a stalled result register holds the input register, which then drops in_ready
// rst_n clears control and parser state; payload registers are not reset
`default_nettype none
`include "http_response_head_parser_defines.svh"

module http_response_head_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       parse_status,
    output logic [2:0]       byte_kind,
    output logic [7:0]       data_byte,
    output logic [7:0]       version_major,
    output logic [7:0]       version_minor,
    output logic [15:0]      status_code,
    output logic [31:0]      body_length
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_restart_reg;
    logic       advance;

    // parser state
    hrhp_pkg::phase_t       phase_reg, phase_next;
    logic [7:0]             major_reg, major_next;
    logic [7:0]             minor_reg, minor_next;
    logic [15:0]            code_reg, code_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [4:0]             pos_reg, pos_next;
    hrhp_pkg::flags_t       flags_reg, flags_next;

    // state seen by this beat, restart applied
    hrhp_pkg::phase_t       cur_phase;
    logic [7:0]             cur_major;
    logic [7:0]             cur_minor;
    logic [15:0]            cur_code;
    logic [LENGTH_BITS-1:0] cur_len;
    logic [LENGTH_BITS-1:0] cur_rem;
    logic [4:0]             cur_pos;
    hrhp_pkg::flags_t       cur_flags;

    // header line byte handling
    logic                   lb_fresh;
    logic [4:0]             lb_pos_in, lb_pos;
    hrhp_pkg::flags_t       lb_flags_in, lb_flags;
    logic [LENGTH_BITS-1:0] lb_len_in, lb_len;
    logic [LENGTH_BITS+3:0] lb_len_wide;
    logic [LENGTH_BITS-1:0] lb_len_sat;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [LENGTH_BITS+31:0] len_ext;

    logic                   bad;
    logic [1:0]             st;
    logic [2:0]             kind;
    logic [31:0]            body_len_calc;

    logic [7:0] c;

    // result register
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  data_reg;
    logic [7:0]  vmaj_reg;
    logic [7:0]  vmin_reg;
    logic [15:0] scode_reg;
    logic [31:0] blen_reg;

    assign c        = in_byte_reg;
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg    <= rx_byte;
            in_restart_reg <= restart;
        end
    end

    always_comb
    begin
        cur_phase = in_restart_reg ? hrhp_pkg::PH_H : phase_reg;
        cur_major = in_restart_reg ? 8'd0 : major_reg;
        cur_minor = in_restart_reg ? 8'd0 : minor_reg;
        cur_code  = in_restart_reg ? 16'd0 : code_reg;
        cur_len   = in_restart_reg ? '0 : len_reg;
        cur_rem   = in_restart_reg ? '0 : rem_reg;
        cur_pos   = in_restart_reg ? hrhp_pkg::POS_NONE : pos_reg;
        cur_flags = in_restart_reg ? '0 : flags_reg;
    end

    // first byte of a line starts from a cleared name match
    always_comb
    begin
        lb_fresh    = (cur_phase == hrhp_pkg::PH_HDR_START);
        lb_pos_in   = cur_pos;
        lb_flags_in = cur_flags;
        lb_len_in   = cur_len;
        if (lb_fresh)
        begin
            lb_pos_in = hrhp_pkg::POS_NONE;
            if (cur_flags.found)
            begin
                lb_flags_in.colon   = 1'b0;
                lb_flags_in.capture = 1'b0;
            end
            else
            begin
                lb_flags_in = '0;
                lb_len_in   = '0;
            end
        end
    end

    assign lb_len_wide = ({4'b0, lb_len_in} << 3) + ({4'b0, lb_len_in} << 1)
                       + {{LENGTH_BITS{1'b0}}, c[3:0]};
    assign lb_len_sat  = (|lb_len_wide[LENGTH_BITS+3:LENGTH_BITS]) ? '1
                       : lb_len_wide[LENGTH_BITS-1:0];

    always_comb
    begin
        lb_pos   = lb_pos_in;
        lb_flags = lb_flags_in;
        lb_len   = lb_len_in;
        if (!lb_flags_in.colon)
        begin
            if (c == hrhp_pkg::CH_COLON)
            begin
                lb_flags.colon = 1'b1;
                if ((lb_pos_in == hrhp_pkg::POS_FULL || lb_pos_in == hrhp_pkg::POS_TRAIL)
                    && !lb_flags_in.found)
                begin
                    lb_flags.capture = 1'b1;
                end
            end
            else if (hrhp_pkg::is_space(c))
            begin
                if (lb_pos_in == hrhp_pkg::POS_FULL)
                begin
                    lb_pos = hrhp_pkg::POS_TRAIL;
                end
                else if (lb_pos_in != hrhp_pkg::POS_NONE && lb_pos_in != hrhp_pkg::POS_TRAIL)
                begin
                    lb_pos = hrhp_pkg::POS_MISS;
                end
            end
            else if (lb_pos_in < hrhp_pkg::POS_FULL)
            begin
                lb_pos = (hrhp_pkg::to_lower(c) == hrhp_pkg::cl_char(lb_pos_in[3:0]))
                       ? lb_pos_in + 5'd1 : hrhp_pkg::POS_MISS;
            end
            else
            begin
                lb_pos = hrhp_pkg::POS_MISS;
            end
        end
        else if (lb_flags_in.capture && !lb_flags_in.vdone)
        begin
            if (hrhp_pkg::is_digit(c))
            begin
                lb_flags.started = 1'b1;
                lb_len           = lb_len_sat;
            end
            else if (!lb_flags_in.started && hrhp_pkg::is_space(c))
            begin
                // leading white space before the value
                lb_len = lb_len_in;
            end
            else if (!lb_flags_in.started
                     && (c == hrhp_pkg::CH_PLUS || c == hrhp_pkg::CH_MINUS))
            begin
                lb_flags.started = 1'b1;
                lb_flags.neg     = (c == hrhp_pkg::CH_MINUS);
            end
            else
            begin
                lb_flags.vdone = 1'b1;
            end
        end
    end

    assign rem_dec = cur_rem - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

    // outputs of the state machine: status, kind, malformed flag
    always_comb
    begin
        bad  = 1'b0;
        st   = hrhp_pkg::ST_MORE;
        kind = hrhp_pkg::KIND_FRAMING;
        case (cur_phase)
            hrhp_pkg::PH_H:     bad = (c != hrhp_pkg::CH_H);
            hrhp_pkg::PH_T1:    bad = (c != hrhp_pkg::CH_T);
            hrhp_pkg::PH_T2:    bad = (c != hrhp_pkg::CH_T);
            hrhp_pkg::PH_P:     bad = (c != hrhp_pkg::CH_P);
            hrhp_pkg::PH_SLASH: bad = (c != hrhp_pkg::CH_SLASH);
            hrhp_pkg::PH_MAJ_START,
            hrhp_pkg::PH_MIN_START,
            hrhp_pkg::PH_CODE_START:
                bad = !hrhp_pkg::is_digit(c);
            hrhp_pkg::PH_MAJ:
                bad = !(c == hrhp_pkg::CH_DOT || hrhp_pkg::is_digit(c));
            hrhp_pkg::PH_MIN,
            hrhp_pkg::PH_CODE:
                bad = !(c == hrhp_pkg::CH_SP || hrhp_pkg::is_digit(c));
            hrhp_pkg::PH_MSG_START:
            begin
                if (hrhp_pkg::is_alpha(c))
                begin
                    kind = hrhp_pkg::KIND_REASON;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            hrhp_pkg::PH_MSG:
            begin
                if (c == hrhp_pkg::CH_CR)
                begin
                    kind = hrhp_pkg::KIND_FRAMING;
                end
                else if (hrhp_pkg::is_alpha(c) || hrhp_pkg::is_digit(c)
                         || hrhp_pkg::is_blank(c))
                begin
                    kind = hrhp_pkg::KIND_REASON;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            hrhp_pkg::PH_NL1,
            hrhp_pkg::PH_NL2:
                bad = (c != hrhp_pkg::CH_LF);
            hrhp_pkg::PH_HDR_START:
                kind = (c == hrhp_pkg::CH_CR) ? hrhp_pkg::KIND_FRAMING : hrhp_pkg::KIND_HEADER;
            hrhp_pkg::PH_HDR:
            begin
                if (c == hrhp_pkg::CH_CR)
                begin
                    // line needs a colon and a nonblank name
                    if (!cur_flags.colon || cur_pos == hrhp_pkg::POS_NONE)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        kind = hrhp_pkg::KIND_LINE_OK;
                    end
                end
                else
                begin
                    kind = hrhp_pkg::KIND_HEADER;
                end
            end
            hrhp_pkg::PH_NL3:
            begin
                if (c != hrhp_pkg::CH_LF || (cur_flags.neg && cur_len != '0))
                begin
                    bad = 1'b1;
                end
                else if (cur_len == '0)
                begin
                    st = hrhp_pkg::ST_DONE;
                end
            end
            hrhp_pkg::PH_BODY:
            begin
                kind = hrhp_pkg::KIND_BODY;
                if (rem_dec == '0)
                begin
                    st = hrhp_pkg::ST_DONE;
                end
            end
            default: bad = 1'b1;
        endcase
        if (bad)
        begin
            st   = hrhp_pkg::ST_BAD;
            kind = hrhp_pkg::KIND_FRAMING;
        end
    end

    // next state; a malformed beat keeps the state it saw
    always_comb
    begin
        phase_next = cur_phase;
        major_next = cur_major;
        minor_next = cur_minor;
        code_next  = cur_code;
        len_next   = cur_len;
        rem_next   = cur_rem;
        pos_next   = cur_pos;
        flags_next = cur_flags;
        if (!bad)
        begin
            case (cur_phase)
                hrhp_pkg::PH_H:     phase_next = hrhp_pkg::PH_T1;
                hrhp_pkg::PH_T1:    phase_next = hrhp_pkg::PH_T2;
                hrhp_pkg::PH_T2:    phase_next = hrhp_pkg::PH_P;
                hrhp_pkg::PH_P:     phase_next = hrhp_pkg::PH_SLASH;
                hrhp_pkg::PH_SLASH: phase_next = hrhp_pkg::PH_MAJ_START;
                hrhp_pkg::PH_MAJ_START:
                begin
                    major_next = {4'b0, c[3:0]};
                    phase_next = hrhp_pkg::PH_MAJ;
                end
                hrhp_pkg::PH_MAJ:
                begin
                    if (c == hrhp_pkg::CH_DOT)
                    begin
                        phase_next = hrhp_pkg::PH_MIN_START;
                    end
                    else
                    begin
                        major_next = hrhp_pkg::sat_dec8(cur_major, c[3:0]);
                    end
                end
                hrhp_pkg::PH_MIN_START:
                begin
                    minor_next = {4'b0, c[3:0]};
                    phase_next = hrhp_pkg::PH_MIN;
                end
                hrhp_pkg::PH_MIN:
                begin
                    if (c == hrhp_pkg::CH_SP)
                    begin
                        phase_next = hrhp_pkg::PH_CODE_START;
                    end
                    else
                    begin
                        minor_next = hrhp_pkg::sat_dec8(cur_minor, c[3:0]);
                    end
                end
                hrhp_pkg::PH_CODE_START:
                begin
                    code_next  = {12'b0, c[3:0]};
                    phase_next = hrhp_pkg::PH_CODE;
                end
                hrhp_pkg::PH_CODE:
                begin
                    if (c == hrhp_pkg::CH_SP)
                    begin
                        phase_next = hrhp_pkg::PH_MSG_START;
                    end
                    else
                    begin
                        code_next = hrhp_pkg::sat_dec16(cur_code, c[3:0]);
                    end
                end
                hrhp_pkg::PH_MSG_START: phase_next = hrhp_pkg::PH_MSG;
                hrhp_pkg::PH_MSG:
                begin
                    if (c == hrhp_pkg::CH_CR)
                    begin
                        phase_next = hrhp_pkg::PH_NL1;
                    end
                end
                hrhp_pkg::PH_NL1,
                hrhp_pkg::PH_NL2:
                    phase_next = hrhp_pkg::PH_HDR_START;
                hrhp_pkg::PH_HDR_START:
                begin
                    if (c == hrhp_pkg::CH_CR)
                    begin
                        phase_next = hrhp_pkg::PH_NL3;
                    end
                    else
                    begin
                        pos_next   = lb_pos;
                        flags_next = lb_flags;
                        len_next   = lb_len;
                        phase_next = hrhp_pkg::PH_HDR;
                    end
                end
                hrhp_pkg::PH_HDR:
                begin
                    if (c == hrhp_pkg::CH_CR)
                    begin
                        if (cur_flags.capture)
                        begin
                            flags_next.capture = 1'b0;
                            flags_next.found   = 1'b1;
                        end
                        phase_next = hrhp_pkg::PH_NL2;
                    end
                    else
                    begin
                        pos_next   = lb_pos;
                        flags_next = lb_flags;
                        len_next   = lb_len;
                    end
                end
                hrhp_pkg::PH_NL3:
                begin
                    if (cur_len == '0)
                    begin
                        phase_next = hrhp_pkg::PH_DONE;
                    end
                    else
                    begin
                        rem_next   = cur_len;
                        phase_next = hrhp_pkg::PH_BODY;
                    end
                end
                hrhp_pkg::PH_BODY:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = hrhp_pkg::PH_DONE;
                    end
                end
                default: phase_next = cur_phase;
            endcase
        end
    end

    // clamp to the 32-bit port; upper slice is zero when LENGTH_BITS <= 32
    assign len_ext       = {32'b0, len_next};
    assign body_len_calc = flags_next.neg ? 32'd0
                         : ((|len_ext[LENGTH_BITS+31:32]) ? 32'hffff_ffff : len_ext[31:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hrhp_pkg::PH_H;
            major_reg <= 8'd0;
            minor_reg <= 8'd0;
            code_reg  <= 16'd0;
            len_reg   <= '0;
            rem_reg   <= '0;
            pos_reg   <= hrhp_pkg::POS_NONE;
            flags_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            major_reg <= major_next;
            minor_reg <= minor_next;
            code_reg  <= code_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= st;
            kind_reg   <= kind;
            data_reg   <= c;
            vmaj_reg   <= major_next;
            vmin_reg   <= minor_next;
            scode_reg  <= code_next;
            blen_reg   <= body_len_calc;
        end
    end

    assign out_valid     = out_valid_reg;
    assign parse_status  = status_reg;
    assign byte_kind     = kind_reg;
    assign data_byte     = data_reg;
    assign version_major = vmaj_reg;
    assign version_minor = vmin_reg;
    assign status_code   = scode_reg;
    assign body_length   = blen_reg;

    `HRHP_ASSERT_NOW(a_bad_is_framing,
        out_valid_reg && status_reg == hrhp_pkg::ST_BAD,
        kind_reg == hrhp_pkg::KIND_FRAMING)
    `HRHP_ASSERT_NOW(a_done_kind,
        out_valid_reg && status_reg == hrhp_pkg::ST_DONE,
        kind_reg == hrhp_pkg::KIND_FRAMING || kind_reg == hrhp_pkg::KIND_BODY)
    `HRHP_ASSERT_NOW(a_body_pending, phase_reg == hrhp_pkg::PH_BODY, rem_reg != '0)
    `HRHP_ASSERT_NEXT(a_input_held, in_valid_reg && !advance, in_valid_reg)

endmodule

`default_nettype wire

FILE: dv/http_response_head_parser_test.sv
`timescale 1ns / 1ps
// self-checking bench for http_response_head_parser: well-formed, damaged and noisy responses
// are streamed one byte per beat and every result beat is checked against a behavioral parser
// depends on hrhp_pkg and the parser rtl

module http_response_head_parser_test;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 400;

    // receiver stall patterns
    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    localparam logic [31:0]     LEN_MAX = 32'hffff_ffff;
    localparam logic [8*14-1:0] CL_NAME = "content-length";

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [7:0]  major;
        logic [7:0]  minor;
        logic [15:0] code;
        logic [31:0] length;
    } parse_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        restart;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  parse_status;
    logic [2:0]  byte_kind;
    logic [7:0]  data_byte;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [15:0] status_code;
    logic [31:0] body_length;

    // behavioral parser state
    hrhp_pkg::phase_t ph;
    logic [7:0]       maj_v;
    logic [7:0]       min_v;
    logic [15:0]      code_v;
    logic [31:0]      len_v;
    logic [31:0]      body_rem;
    logic [4:0]       npos;
    hrhp_pkg::flags_t fl;

    parse_result_t parsed_q[$];
    parse_result_t got;
    parse_result_t want;
    logic [7:0]    msg_q[$];

    int errors      = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int cycle_count = 0;
    bit hold_req    = 0;

    http_response_head_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .parse_status  (parse_status),
        .byte_kind     (byte_kind),
        .data_byte     (data_byte),
        .version_major (version_major),
        .version_minor (version_minor),
        .status_code   (status_code),
        .body_length   (body_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------- behavioral parser ----------------

    function automatic bit is_num(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic bit is_ws(input logic [7:0] c);
        return (c == hrhp_pkg::CH_SP) || ((c >= hrhp_pkg::CH_TAB) && (c <= hrhp_pkg::CH_CR));
    endfunction

    // acc*10 + digit, pinned at maxv
    function automatic logic [31:0] dec_sat(input logic [31:0] acc, input logic [7:0] c,
                                            input logic [31:0] maxv);
        logic [31:0] d;
        d = 32'(c - "0");
        if (acc > (maxv - d) / 10)
            return maxv;
        return acc * 10 + d;
    endfunction

    function automatic void clear_parser();
        ph       = hrhp_pkg::PH_H;
        maj_v    = '0;
        min_v    = '0;
        code_v   = '0;
        len_v    = '0;
        body_rem = '0;
        npos     = hrhp_pkg::POS_NONE;
        fl       = '0;
    endfunction

    // one byte of a header line: name matching before the colon, length digits after it
    function automatic void header_char(input logic [7:0] c);
        logic [7:0] low;
        low = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
        if (!fl.colon)
        begin
            if (c == hrhp_pkg::CH_COLON)
            begin
                fl.colon = 1'b1;
                if ((npos == hrhp_pkg::POS_FULL || npos == hrhp_pkg::POS_TRAIL) && !fl.found)
                    fl.capture = 1'b1;
            end
            else if (is_ws(c))
            begin
                if (npos == hrhp_pkg::POS_FULL)
                    npos = hrhp_pkg::POS_TRAIL;
                else if (npos != hrhp_pkg::POS_NONE && npos != hrhp_pkg::POS_TRAIL)
                    npos = hrhp_pkg::POS_MISS;
            end
            else if (npos < hrhp_pkg::POS_FULL)
            begin
                npos = (low == CL_NAME[8*(13-npos) +: 8]) ? npos + 5'd1 : hrhp_pkg::POS_MISS;
            end
            else
            begin
                npos = hrhp_pkg::POS_MISS;
            end
        end
        else if (fl.capture && !fl.vdone)
        begin
            if (is_num(c))
            begin
                fl.started = 1'b1;
                len_v = dec_sat(len_v, c, LEN_MAX);
            end
            else if (!fl.started && is_ws(c))
            begin
                // leading blanks skipped
            end
            else if (!fl.started && (c == hrhp_pkg::CH_PLUS || c == hrhp_pkg::CH_MINUS))
            begin
                fl.started = 1'b1;
                if (c == hrhp_pkg::CH_MINUS)
                    fl.neg = 1'b1;
            end
            else
            begin
                fl.vdone = 1'b1;
            end
        end
    endfunction

    function automatic parse_result_t parse_byte(input logic [7:0] c, input logic rs);
        parse_result_t r;
        bit bad;
        bad    = 1'b0;
        r.status = hrhp_pkg::ST_MORE;
        r.kind   = hrhp_pkg::KIND_FRAMING;
        if (rs)
            clear_parser();
        case (ph)
            hrhp_pkg::PH_H:
                if (c == hrhp_pkg::CH_H) ph = hrhp_pkg::PH_T1; else bad = 1'b1;
            hrhp_pkg::PH_T1:
                if (c == hrhp_pkg::CH_T) ph = hrhp_pkg::PH_T2; else bad = 1'b1;
            hrhp_pkg::PH_T2:
                if (c == hrhp_pkg::CH_T) ph = hrhp_pkg::PH_P; else bad = 1'b1;
            hrhp_pkg::PH_P:
                if (c == hrhp_pkg::CH_P) ph = hrhp_pkg::PH_SLASH; else bad = 1'b1;
            hrhp_pkg::PH_SLASH:
                if (c == hrhp_pkg::CH_SLASH) ph = hrhp_pkg::PH_MAJ_START; else bad = 1'b1;
            hrhp_pkg::PH_MAJ_START:
                if (is_num(c))
                begin
                    maj_v = c - "0";
                    ph = hrhp_pkg::PH_MAJ;
                end
                else bad = 1'b1;
            hrhp_pkg::PH_MAJ:
                if (c == hrhp_pkg::CH_DOT) ph = hrhp_pkg::PH_MIN_START;
                else if (is_num(c)) maj_v = 8'(dec_sat(32'(maj_v), c, 32'd255));
                else bad = 1'b1;
            hrhp_pkg::PH_MIN_START:
                if (is_num(c))
                begin
                    min_v = c - "0";
                    ph = hrhp_pkg::PH_MIN;
                end
                else bad = 1'b1;
            hrhp_pkg::PH_MIN:
                if (c == hrhp_pkg::CH_SP) ph = hrhp_pkg::PH_CODE_START;
                else if (is_num(c)) min_v = 8'(dec_sat(32'(min_v), c, 32'd255));
                else bad = 1'b1;
            hrhp_pkg::PH_CODE_START:
                if (is_num(c))
                begin
                    code_v = 16'(c - "0");
                    ph = hrhp_pkg::PH_CODE;
                end
                else bad = 1'b1;
            hrhp_pkg::PH_CODE:
                if (c == hrhp_pkg::CH_SP) ph = hrhp_pkg::PH_MSG_START;
                else if (is_num(c)) code_v = 16'(dec_sat(32'(code_v), c, 32'd65535));
                else bad = 1'b1;
            hrhp_pkg::PH_MSG_START:
                if (is_letter(c))
                begin
                    r.kind = hrhp_pkg::KIND_REASON;
                    ph = hrhp_pkg::PH_MSG;
                end
                else bad = 1'b1;
            hrhp_pkg::PH_MSG:
                if (c == hrhp_pkg::CH_CR) ph = hrhp_pkg::PH_NL1;
                else if (is_letter(c) || is_num(c) || c == hrhp_pkg::CH_SP
                         || c == hrhp_pkg::CH_TAB)
                    r.kind = hrhp_pkg::KIND_REASON;
                else bad = 1'b1;
            hrhp_pkg::PH_NL1:
                if (c == hrhp_pkg::CH_LF) ph = hrhp_pkg::PH_HDR_START; else bad = 1'b1;
            hrhp_pkg::PH_NL2:
                if (c == hrhp_pkg::CH_LF) ph = hrhp_pkg::PH_HDR_START; else bad = 1'b1;
            hrhp_pkg::PH_HDR_START:
                if (c == hrhp_pkg::CH_CR)
                    ph = hrhp_pkg::PH_NL3;
                else
                begin
                    npos = hrhp_pkg::POS_NONE;
                    if (fl.found)
                    begin
                        fl.colon   = 1'b0;
                        fl.capture = 1'b0;
                    end
                    else
                    begin
                        fl    = '0;
                        len_v = '0;
                    end
                    header_char(c);
                    r.kind = hrhp_pkg::KIND_HEADER;
                    ph = hrhp_pkg::PH_HDR;
                end
            hrhp_pkg::PH_HDR:
                if (c == hrhp_pkg::CH_CR)
                begin
                    // line needs a colon and a nonblank name, else it stays open
                    if (!fl.colon || npos == hrhp_pkg::POS_NONE)
                        bad = 1'b1;
                    else
                    begin
                        if (fl.capture)
                        begin
                            fl.capture = 1'b0;
                            fl.found   = 1'b1;
                        end
                        r.kind = hrhp_pkg::KIND_LINE_OK;
                        ph = hrhp_pkg::PH_NL2;
                    end
                end
                else
                begin
                    header_char(c);
                    r.kind = hrhp_pkg::KIND_HEADER;
                end
            hrhp_pkg::PH_NL3:
                if (c != hrhp_pkg::CH_LF || (fl.neg && len_v != 0))
                    bad = 1'b1;
                else if (len_v == 0)
                begin
                    r.status = hrhp_pkg::ST_DONE;
                    ph = hrhp_pkg::PH_DONE;
                end
                else
                begin
                    body_rem = len_v;
                    ph = hrhp_pkg::PH_BODY;
                end
            hrhp_pkg::PH_BODY:
            begin
                r.kind = hrhp_pkg::KIND_BODY;
                body_rem = body_rem - 32'd1;
                if (body_rem == 0)
                begin
                    r.status = hrhp_pkg::ST_DONE;
                    ph = hrhp_pkg::PH_DONE;
                end
            end
            default: bad = 1'b1;
        endcase
        if (bad)
        begin
            r.status = hrhp_pkg::ST_BAD;
            r.kind   = hrhp_pkg::KIND_FRAMING;
        end
        r.data   = c;
        r.major  = maj_v;
        r.minor  = min_v;
        r.code   = code_v;
        r.length = fl.neg ? 32'd0 : len_v;
        return r;
    endfunction

    // ---------------- result checking ----------------

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got = {parse_status, byte_kind, data_byte, version_major, version_minor,
                   status_code, body_length};
            if (parsed_q.size() == 0)
            begin
                $display("%0t: result beat with none expected, expected nothing, actual %h",
                         $time, got);
                errors++;
            end
            else
            begin
                want = parsed_q.pop_front();
                compare_field("parse_status", 32'(want.status), 32'(got.status));
                compare_field("byte_kind", 32'(want.kind), 32'(got.kind));
                compare_field("data_byte", 32'(want.data), 32'(got.data));
                compare_field("version_major", 32'(want.major), 32'(got.major));
                compare_field("version_minor", 32'(want.minor), 32'(got.minor));
                compare_field("status_code", 32'(want.code), 32'(got.code));
                compare_field("body_length", want.length, got.length);
            end
        end
    end

    // ---------------- receiver ----------------

    initial
    begin : receiver
        int mode;
        int mode_left;
        int period;
        int tick;
        int hold_left;
        mode      = RX_ALWAYS;
        mode_left = 0;
        period    = 2;
        tick      = 0;
        hold_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                // long hold-off so the block backs up into its input
                hold_left--;
                if (hold_left == 0)
                    hold_req = 1'b0;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(RX_ALWAYS, RX_PERIODIC);
                    mode_left = $urandom_range(20, 200);
                    period    = $urandom_range(2, 7);
                    tick      = 0;
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_ALWAYS: out_ready <= 1'b1;
                    RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
                    default:   out_ready <= (tick % period) != 0;
                endcase
            end
        end
    end

    // ---------------- sender ----------------

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [7:0] b, input logic rs);
        int            gap;
        parse_result_t exp_r;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        restart  <= rs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        exp_r    = parse_byte(b, rs);
        parsed_q = {parsed_q, exp_r};
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_msg(input bit first_restart);
        foreach (msg_q[i])
            send_beat(msg_q[i], (i == 0) ? first_restart : ($urandom_range(0, 299) == 0));
    endtask

    function automatic void add_byte(input logic [7:0] b);
        msg_q = {msg_q, b};
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void push_digits(input int n);
        repeat (n) add_byte(8'("0" + $urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_blank();
        return $urandom_range(0, 1) ? hrhp_pkg::CH_SP : hrhp_pkg::CH_TAB;
    endfunction

    // version numbers, now and then around the saturation point
    function automatic void push_version();
        case ($urandom_range(0, 7))
            0:       push_text($sformatf("%0d", $urandom_range(250, 260)));
            1:       push_digits($urandom_range(2, 5));
            default: push_digits(1);
        endcase
    endfunction

    function automatic void build_response();
        int         k;
        int         m;
        int         pos;
        logic [7:0] ch;
        msg_q.delete();
        push_text("HTTP/");
        push_version();
        add_byte(hrhp_pkg::CH_DOT);
        push_version();
        add_byte(hrhp_pkg::CH_SP);
        case ($urandom_range(0, 5))
            0:       push_text($sformatf("%0d", $urandom_range(65530, 65540)));
            1:       push_digits($urandom_range(1, 7));
            default: push_text($sformatf("%0d", $urandom_range(100, 599)));
        endcase
        add_byte(hrhp_pkg::CH_SP);
        add_byte(rand_letter());
        repeat ($urandom_range(0, 8))
        begin
            case ($urandom_range(0, 3))
                0:       push_digits(1);
                1:       add_byte(rand_blank());
                default: add_byte(rand_letter());
            endcase
        end
        add_byte(hrhp_pkg::CH_CR);
        add_byte(hrhp_pkg::CH_LF);
        repeat ($urandom_range(0, 3))
        begin
            k = $urandom_range(0, 19);
            if (k < 8)
            begin
                // content-length in mixed case with optional blanks and sign
                if ($urandom_range(0, 3) == 0)
                    add_byte(hrhp_pkg::CH_SP);
                for (int i = 0; i < 14; i++)
                begin
                    ch = CL_NAME[8*(13-i) +: 8];
                    if (ch >= "a" && $urandom_range(0, 1))
                        ch = ch - 8'd32;
                    add_byte(ch);
                end
                if ($urandom_range(0, 3) == 0)
                    add_byte(rand_blank());
                add_byte(hrhp_pkg::CH_COLON);
                repeat ($urandom_range(0, 2)) add_byte(rand_blank());
                m = $urandom_range(0, 9);
                if (m == 0)
                    add_byte(hrhp_pkg::CH_MINUS);
                else if (m == 1)
                    add_byte(hrhp_pkg::CH_PLUS);
                if ($urandom_range(0, 7) == 0)
                    push_digits($urandom_range(9, 12));
                else
                    push_text($sformatf("%0d", $urandom_range(0, 24)));
                if ($urandom_range(0, 4) == 0)
                    push_text(" x");
            end
            else if (k < 13)
            begin
                repeat ($urandom_range(1, 6)) add_byte(rand_letter());
                add_byte(hrhp_pkg::CH_COLON);
                add_byte(hrhp_pkg::CH_SP);
                repeat ($urandom_range(0, 6)) add_byte($urandom_range(0, 1) ?
                                                       rand_letter() : 8'h37);
            end
            else if (k < 16)
            begin
                // near miss on the name
                m = $urandom_range(1, 13);
                case ($urandom_range(0, 2))
                    0: for (int i = 0; i < m; i++) add_byte(CL_NAME[8*(13-i) +: 8]);
                    1: push_text("Content-Lengths");
                    default: push_text("Content-Length x");
                endcase
                push_text(": 5");
            end
            else if (k < 19)
            begin
                // stray cr before the colon, then the line goes on
                repeat ($urandom_range(1, 3)) add_byte(rand_letter());
                add_byte(hrhp_pkg::CH_CR);
                push_text(": 3");
            end
            else
            begin
                // empty name can never be accepted
                push_text(" : 9");
            end
            add_byte(hrhp_pkg::CH_CR);
            add_byte(hrhp_pkg::CH_LF);
        end
        add_byte(hrhp_pkg::CH_CR);
        add_byte(hrhp_pkg::CH_LF);
        if ($urandom_range(0, 7) == 0)
        begin
            pos = $urandom_range(0, msg_q.size() - 1);
            if ($urandom_range(0, 1))
                msg_q[pos] = 8'($urandom_range(0, 255));
            else
                msg_q.insert(pos, 8'($urandom_range(0, 255)));
        end
    endfunction

    // ---------------- tests ----------------

    task automatic test_prefix_bytes();
        send_beat(8'h00, 1'b1);
        send_beat(8'hff, 1'b0);
        send_beat(hrhp_pkg::CH_H, 1'b1);
        send_beat(hrhp_pkg::CH_P, 1'b0);
    endtask

    task automatic test_minimal_response();
        msg_q.delete();
        push_text("HTTP/1.1 200 OK");
        add_byte(hrhp_pkg::CH_CR);
        add_byte(hrhp_pkg::CH_LF);
        add_byte(hrhp_pkg::CH_CR);
        add_byte(hrhp_pkg::CH_LF);
        send_msg(1'b1);
        // anything after completion is malformed
        send_beat(hrhp_pkg::CH_H, 1'b0);
    endtask

    task automatic test_back_pressure();
        hold_req = 1'b1;
        build_response();
        send_msg(1'b1);
    endtask

    task automatic test_random_responses();
        int body_n;
        while (items_sent < 1200)
        begin
            build_response();
            send_msg($urandom_range(0, 15) != 0);
            if (ph == hrhp_pkg::PH_BODY)
            begin
                body_n = (body_rem <= 32'd40) ? int'(body_rem) : $urandom_range(1, 40);
                repeat (body_n) send_beat(8'($urandom_range(0, 255)), 1'b0);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic test_random_noise();
        repeat (150) send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    endtask

    initial
    begin
        in_valid = 1'b0;
        rx_byte  = 8'h00;
        restart  = 1'b0;
        rst_n    = 1'b0;
        clear_parser();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_prefix_bytes();
        test_minimal_response();
        test_back_pressure();
        test_random_responses();
        test_random_noise();

        in_valid <= 1'b0;
        while (parsed_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
